// ===== design/lcdw_pkg.sv =====
// shared types, codes and microcode table for the lcd number writer
package lcdw_pkg;

  localparam logic [2:0] OP_CHAR = 3'd0;
  localparam logic [2:0] OP_UDEC = 3'd1;
  localparam logic [2:0] OP_SDEC = 3'd2;
  localparam logic [2:0] OP_HEX  = 3'd3;
  localparam logic [2:0] OP_BIN  = 3'd4;

  localparam logic [7:0] CMD_SET_ADDR = 8'h80;
  localparam logic [7:0] ROW2_OFFSET  = 8'h40;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_A         = 8'h41;
  localparam logic [7:0] CH_PLUS      = 8'h2B;
  localparam logic [7:0] CH_MINUS     = 8'h2D;

  localparam int DEC_DIGITS = 5;
  localparam int HEX_DIGITS = 4;
  localparam int BIN_DIGITS = 16;

  typedef struct packed {
    logic [2:0]  op;
    logic [1:0]  row_sel;
    logic [4:0]  col_pos;
    logic [15:0] num_value;
    logic [4:0]  digit_count;
    logic [7:0]  char_code;
  } lcdw_in_t;

  typedef struct packed {
    logic       is_data;
    logic [7:0] bus_byte;
    logic       last;
  } lcdw_out_t;

  typedef logic [DEC_DIGITS-1:0][3:0] bcd_t;

  typedef enum logic [2:0] {
    STEP_FETCH,
    STEP_ADDR,
    STEP_SIGN,
    STEP_CONV,
    STEP_DIGIT,
    STEP_CHAR
  } step_t;

  typedef enum logic [2:0] {
    EMIT_NONE,
    EMIT_ADDR,
    EMIT_SIGN,
    EMIT_DIGIT,
    EMIT_CHAR
  } emit_t;

  typedef enum logic [1:0] {
    BR_NEXT,
    BR_OP,
    BR_CONV,
    BR_STAY
  } br_t;

  typedef struct packed {
    logic  take;
    emit_t emit;
    logic  conv;
    br_t   br;
  } ctrl_t;

  // microcode: one control word per step
  function automatic ctrl_t ucode_rom(input step_t step);
    ctrl_t w;
    w = '{take: 1'b0, emit: EMIT_NONE, conv: 1'b0, br: BR_STAY};
    case (step)
      STEP_FETCH: w = '{take: 1'b1, emit: EMIT_NONE,  conv: 1'b0, br: BR_NEXT};
      STEP_ADDR:  w = '{take: 1'b0, emit: EMIT_ADDR,  conv: 1'b0, br: BR_OP};
      STEP_SIGN:  w = '{take: 1'b0, emit: EMIT_SIGN,  conv: 1'b0, br: BR_NEXT};
      STEP_CONV:  w = '{take: 1'b0, emit: EMIT_NONE,  conv: 1'b1, br: BR_CONV};
      STEP_DIGIT: w = '{take: 1'b0, emit: EMIT_DIGIT, conv: 1'b0, br: BR_STAY};
      STEP_CHAR:  w = '{take: 1'b0, emit: EMIT_CHAR,  conv: 1'b0, br: BR_STAY};
      default:    w = '{take: 1'b1, emit: EMIT_NONE,  conv: 1'b0, br: BR_NEXT};
    endcase
    return w;
  endfunction

endpackage

// ===== design/lcdw_dabble.sv =====
// shift-and-add-3 binary to bcd converter, one bit per step
module lcdw_dabble (
  input  logic               clk,
  input  logic               load,
  input  logic               step,
  input  logic [15:0]        din,
  output lcdw_pkg::bcd_t     bcd,
  output logic               final_step
);
  import lcdw_pkg::*;

  logic [15:0] bin;
  logic [3:0]  bits;
  bcd_t        adj;

  always_comb begin
    for (int k = 0; k < DEC_DIGITS; k++) begin
      adj[k] = (bcd[k] >= 4'd5) ? 4'(bcd[k] + 4'd3) : bcd[k];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bin  <= din;
      bcd  <= '0;
      bits <= '0;
    end else if (step) begin
      bcd  <= {adj[DEC_DIGITS-1][2:0], adj[DEC_DIGITS-2:0], bin[15]};
      bin  <= {bin[14:0], 1'b0};
      bits <= 4'(bits + 4'd1);
    end
  end

  // the sixteenth shift is under way
  assign final_step = (bits == 4'd15);

endmodule

// ===== design/lcd_number_to_char_writer.sv =====
// top level: microcoded formatter that turns a print request into lcd bus bytes
// an accepted request goes to the address step, which registers the address command
// decimal requests run the bcd converter before the first digit
// throughput: one output byte per cycle in the emitting steps while out_ready is high;
// each request also passes the fetch step, and decimal ones the conversion steps
// reset: sequencer returns to fetch and the output register is emptied
module lcd_number_to_char_writer (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  lcdw_pkg::lcdw_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output lcdw_pkg::lcdw_out_t out_data
);
  import lcdw_pkg::*;

  step_t      upc, upc_next;
  ctrl_t      ctrl;

  logic [2:0]  op;
  logic [7:0]  addr;
  logic [4:0]  cnt;
  logic [15:0] val;
  logic [7:0]  ch;
  logic        neg;

  logic        emit_fire;
  logic        load;
  logic        emit_last;
  logic [7:0]  emit_byte;
  logic        emit_data;

  logic [7:0]  addr_in;
  logic [7:0]  col_m1;
  logic [4:0]  cnt_in;
  logic        neg_in;
  logic [15:0] mag_in;
  logic [4:0]  cnt_m1;
  logic [3:0]  idx;
  logic [3:0]  hex_d;
  bcd_t        bcd;
  logic        conv_final;

  // request decode at the input transaction
  always_comb begin
    col_m1  = 8'(8'(in_data.col_pos) - 8'd1);
    addr_in = (in_data.row_sel == 2'd1) ? (CMD_SET_ADDR | col_m1)
                                        : (CMD_SET_ADDR | 8'(col_m1 + ROW2_OFFSET));
    neg_in  = (in_data.op == OP_SDEC) && in_data.num_value[15];
    mag_in  = neg_in ? 16'(~in_data.num_value + 16'd1) : in_data.num_value;
    case (in_data.op)
      OP_UDEC, OP_SDEC: cnt_in = (in_data.digit_count > 5'(DEC_DIGITS))
                                 ? 5'(DEC_DIGITS) : in_data.digit_count;
      OP_HEX:           cnt_in = (in_data.digit_count > 5'(HEX_DIGITS))
                                 ? 5'(HEX_DIGITS) : in_data.digit_count;
      OP_BIN:           cnt_in = (in_data.digit_count > 5'(BIN_DIGITS))
                                 ? 5'(BIN_DIGITS) : in_data.digit_count;
      default:          cnt_in = in_data.digit_count;
    endcase
  end

  lcdw_dabble u_dabble (
    .clk        (clk),
    .load       (load),
    .step       (ctrl.conv),
    .din        (mag_in),
    .bcd        (bcd),
    .final_step (conv_final)
  );

  // digit selected by the remaining count, most significant first
  always_comb begin
    cnt_m1 = 5'(cnt - 5'd1);
    idx    = cnt_m1[3:0];
    hex_d  = val[{idx[1:0], 2'b00} +: 4];
  end

  // control word decode and emitted byte
  always_comb begin
    ctrl      = ucode_rom(upc);
    in_ready  = ctrl.take;
    load      = ctrl.take && in_valid;
    emit_fire = (ctrl.emit != EMIT_NONE) && (!out_valid || out_ready);
    emit_data = 1'b1;
    emit_byte = ch;
    emit_last = 1'b1;
    case (ctrl.emit)
      EMIT_ADDR: begin
        emit_data = 1'b0;
        emit_byte = addr;
        emit_last = (op > OP_BIN) || ((op inside {OP_UDEC, OP_HEX, OP_BIN}) && (cnt == 5'd0));
      end
      EMIT_SIGN: begin
        emit_byte = neg ? CH_MINUS : CH_PLUS;
        emit_last = (cnt == 5'd0);
      end
      EMIT_DIGIT: begin
        emit_last = (cnt == 5'd1);
        case (op)
          OP_HEX:  emit_byte = (hex_d < 4'd10) ? 8'(CH_ZERO + 8'(hex_d))
                                               : 8'(CH_A + 8'(hex_d) - 8'd10);
          OP_BIN:  emit_byte = 8'(CH_ZERO + 8'(val[idx]));
          default: emit_byte = 8'(CH_ZERO + 8'(bcd[idx[2:0]]));
        endcase
      end
      EMIT_CHAR: begin
        emit_byte = ch;
        emit_last = 1'b1;
      end
      default: begin
        emit_data = 1'b1;
        emit_byte = ch;
        emit_last = 1'b0;
      end
    endcase
  end

  // next step
  always_comb begin
    upc_next = upc;
    if (ctrl.emit != EMIT_NONE && !emit_fire) begin
      upc_next = upc;
    end else if (emit_fire && emit_last) begin
      upc_next = STEP_FETCH;
    end else begin
      case (ctrl.br)
        BR_NEXT: begin
          if (!ctrl.take || in_valid) upc_next = step_t'(3'(upc) + 3'd1);
        end
        BR_OP: begin
          case (op)
            OP_CHAR:        upc_next = STEP_CHAR;
            OP_UDEC:        upc_next = STEP_CONV;
            OP_SDEC:        upc_next = STEP_SIGN;
            OP_HEX, OP_BIN: upc_next = STEP_DIGIT;
            default:        upc_next = STEP_FETCH;
          endcase
        end
        BR_CONV: begin
          if (conv_final) upc_next = STEP_DIGIT;
        end
        default: upc_next = upc;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= STEP_FETCH;
    end else begin
      upc <= upc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      op   <= in_data.op;
      addr <= addr_in;
      cnt  <= cnt_in;
      val  <= in_data.num_value;
      ch   <= in_data.char_code;
      neg  <= neg_in;
    end else if (emit_fire && ctrl.emit == EMIT_DIGIT) begin
      cnt <= cnt_m1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_data <= '{is_data: emit_data, bus_byte: emit_byte, last: emit_last};
    end
  end

  a_accept_to_addr: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> upc == STEP_ADDR)
    else $error("accepted request did not move to the address step");

  a_digit_count: assert property (@(posedge clk) disable iff (rst)
    upc == STEP_DIGIT |-> cnt != 5'd0)
    else $error("digit step entered with no digits left");

  a_conv_decimal: assert property (@(posedge clk) disable iff (rst)
    upc == STEP_CONV |-> (op == OP_UDEC || op == OP_SDEC))
    else $error("bcd conversion for a non-decimal request");

  a_last_returns: assert property (@(posedge clk) disable iff (rst)
    emit_fire && emit_last |=> upc == STEP_FETCH && out_valid && out_data.last)
    else $error("final byte did not end the request");

endmodule

// ===== tb/tb.sv =====
// self-checking testbench for the lcd number writer: directed table, then random requests
module tb;
  import lcdw_pkg::*;

  localparam logic [2:0] OP_RSVD5 = 3'd5;
  localparam logic [2:0] OP_RSVD6 = 3'd6;
  localparam logic [2:0] OP_RSVD7 = 3'd7;

  localparam int N_RANDOM       = 145;
  localparam int PAUSE_EVERY    = 40;
  localparam int DRAIN_CYCLES   = 40;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS    = 10;

  localparam lcdw_out_t NO_BYTE = '0;

  typedef struct packed {
    lcdw_in_t             req;
    logic [1:0]           n_typed;
    logic [2:0][9:0]      typed;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  lcdw_in_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  lcdw_out_t out_data;

  lcdw_out_t expected_bytes [$];
  dir_row_t  dir_table [$];
  int        fail_count = 0;
  int        bytes_checked = 0;
  int        idle_cycles = 0;
  int        op_seen [8];
  int        ready_run = 0;

  lcd_number_to_char_writer dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic dir_row_t dir_row(input logic [2:0] op, input logic [1:0] row,
                                       input logic [4:0] col, input logic [15:0] val,
                                       input logic [4:0] cnt, input logic [7:0] ch,
                                       input int n, input lcdw_out_t e0,
                                       input lcdw_out_t e1, input lcdw_out_t e2);
    dir_row_t r;
    r.req.op          = op;
    r.req.row_sel     = row;
    r.req.col_pos     = col;
    r.req.num_value   = val;
    r.req.digit_count = cnt;
    r.req.char_code   = ch;
    r.n_typed         = n[1:0];
    r.typed[0]        = e0;
    r.typed[1]        = e1;
    r.typed[2]        = e2;
    return r;
  endfunction

  // bus bytes that one print request must produce, appended to expected_bytes
  function automatic void format_request(input lcdw_in_t req);
    lcdw_out_t   seq [$];
    lcdw_out_t   b;
    logic [7:0]  col_off;
    logic [7:0]  addr;
    logic [7:0]  digit;
    logic [16:0] mag;
    logic [3:0]  nib;
    int unsigned weight;
    int          ndig;
    int          i;
    col_off = {3'b000, req.col_pos} - 8'd1;
    addr = CMD_SET_ADDR | ((req.row_sel == 2'd1) ? col_off : col_off + ROW2_OFFSET);
    seq.push_back({1'b0, addr, 1'b0});
    mag = {1'b0, req.num_value};
    case (req.op)
      OP_CHAR: seq.push_back({1'b1, req.char_code, 1'b0});
      OP_UDEC, OP_SDEC: begin
        if (req.op == OP_SDEC) begin
          if (req.num_value[15]) begin
            seq.push_back({1'b1, CH_MINUS, 1'b0});
            mag = 17'h10000 - mag;
          end else begin
            seq.push_back({1'b1, CH_PLUS, 1'b0});
          end
        end
        ndig = (req.digit_count > DEC_DIGITS) ? DEC_DIGITS : int'(req.digit_count);
        for (i = ndig; i > 0; i--) begin
          weight = 1;
          repeat (i - 1) weight = weight * 10;
          digit = CH_ZERO + 8'((mag / weight) % 10);
          seq.push_back({1'b1, digit, 1'b0});
        end
      end
      OP_HEX: begin
        ndig = (req.digit_count > HEX_DIGITS) ? HEX_DIGITS : int'(req.digit_count);
        for (i = ndig; i > 0; i--) begin
          nib = 4'(mag >> (4 * (i - 1)));
          digit = (nib < 4'd10) ? CH_ZERO + 8'(nib) : CH_A + 8'(nib) - 8'd10;
          seq.push_back({1'b1, digit, 1'b0});
        end
      end
      OP_BIN: begin
        ndig = (req.digit_count > BIN_DIGITS) ? BIN_DIGITS : int'(req.digit_count);
        for (i = ndig; i > 0; i--) begin
          digit = CH_ZERO + 8'(mag[i-1]);
          seq.push_back({1'b1, digit, 1'b0});
        end
      end
      default: ;
    endcase
    for (i = 0; i < seq.size(); i++) begin
      b = seq[i];
      b.last = (i == seq.size() - 1);
      expected_bytes.push_back(b);
    end
  endfunction

  function automatic void note_failure(input string msg);
    if (fail_count < MAX_REPORTS) $display("ERROR: %s", msg);
    fail_count++;
  endfunction

  // holds the request until the block takes it
  task automatic send_request(input lcdw_in_t req);
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    op_seen[req.op]++;
  endtask

  // output side: check each transaction, then move the stall pattern along
  always @(posedge clk) begin : rx_side
    lcdw_out_t want;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      bytes_checked++;
      if (expected_bytes.size() == 0) begin
        note_failure($sformatf("unexpected byte data=%b byte=%h last=%b",
                               out_data.is_data, out_data.bus_byte, out_data.last));
      end else begin
        want = expected_bytes.pop_front();
        if (out_data.is_data !== want.is_data || out_data.bus_byte !== want.bus_byte ||
            out_data.last !== want.last)
          note_failure($sformatf("byte %0d: expected data=%b byte=%h last=%b, got %b %h %b",
                                 bytes_checked, want.is_data, want.bus_byte, want.last,
                                 out_data.is_data, out_data.bus_byte, out_data.last));
      end
    end
    if (ready_run == 0) begin
      if (out_ready) begin
        out_ready <= 1'b0;
        ready_run = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 15 : 3);
      end else begin
        out_ready <= 1'b1;
        ready_run = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
      end
    end else begin
      ready_run = ready_run - 1;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
    $display("** lcd_number_to_char_writer: FAILED **");
    $finish;
  end

  initial begin
    lcdw_in_t req;
    dir_row_t r;
    int       k;
    int       j;
    int       burst_left;
    int       gap;

    // rows with typed bytes: unused ops, column and row wrap, zero digit counts, one single digit
    dir_table.push_back(dir_row(OP_RSVD5, 2'd1, 5'd1, 16'h0000, 5'd0, 8'h00, 1,
                                {1'b0, 8'h80, 1'b1}, NO_BYTE, NO_BYTE));
    dir_table.push_back(dir_row(OP_RSVD7, 2'd2, 5'd16, 16'hFFFF, 5'd31, 8'hFF, 1,
                                {1'b0, 8'hCF, 1'b1}, NO_BYTE, NO_BYTE));
    dir_table.push_back(dir_row(OP_RSVD6, 2'd1, 5'd0, 16'h1234, 5'd3, 8'h55, 1,
                                {1'b0, 8'hFF, 1'b1}, NO_BYTE, NO_BYTE));
    dir_table.push_back(dir_row(OP_CHAR, 2'd0, 5'd0, 16'h0000, 5'd31, 8'hFF, 2,
                                {1'b0, 8'hBF, 1'b0}, {1'b1, 8'hFF, 1'b1}, NO_BYTE));
    dir_table.push_back(dir_row(OP_CHAR, 2'd3, 5'd31, 16'hFFFF, 5'd0, 8'h00, 2,
                                {1'b0, 8'hDE, 1'b0}, {1'b1, 8'h00, 1'b1}, NO_BYTE));
    dir_table.push_back(dir_row(OP_SDEC, 2'd1, 5'd1, 16'h8000, 5'd0, 8'h00, 2,
                                {1'b0, 8'h80, 1'b0}, {1'b1, CH_MINUS, 1'b1}, NO_BYTE));
    dir_table.push_back(dir_row(OP_SDEC, 2'd2, 5'd1, 16'h0000, 5'd0, 8'h00, 2,
                                {1'b0, 8'hC0, 1'b0}, {1'b1, CH_PLUS, 1'b1}, NO_BYTE));
    dir_table.push_back(dir_row(OP_UDEC, 2'd1, 5'd16, 16'hFFFF, 5'd0, 8'h00, 1,
                                {1'b0, 8'h8F, 1'b1}, NO_BYTE, NO_BYTE));
    dir_table.push_back(dir_row(OP_HEX, 2'd2, 5'd16, 16'hFFFF, 5'd0, 8'h00, 1,
                                {1'b0, 8'hCF, 1'b1}, NO_BYTE, NO_BYTE));
    dir_table.push_back(dir_row(OP_BIN, 2'd1, 5'd2, 16'hFFFF, 5'd0, 8'h00, 1,
                                {1'b0, 8'h81, 1'b1}, NO_BYTE, NO_BYTE));
    dir_table.push_back(dir_row(OP_UDEC, 2'd1, 5'd1, 16'h0000, 5'd1, 8'h00, 2,
                                {1'b0, 8'h80, 1'b0}, {1'b1, CH_ZERO, 1'b1}, NO_BYTE));
    // remaining rows go through the predictor: clamps, truncation, sign edges, all digits
    dir_table.push_back(dir_row(OP_UDEC, 2'd2, 5'd31, 16'hFFFF, 5'd31, 8'hAA, 0,
                                NO_BYTE, NO_BYTE, NO_BYTE));
    dir_table.push_back(dir_row(OP_UDEC, 2'd1, 5'd5, 16'd12345, 5'd2, 8'h00, 0,
                                NO_BYTE, NO_BYTE, NO_BYTE));
    dir_table.push_back(dir_row(OP_SDEC, 2'd1, 5'd3, 16'h8000, 5'd5, 8'h00, 0,
                                NO_BYTE, NO_BYTE, NO_BYTE));
    dir_table.push_back(dir_row(OP_SDEC, 2'd2, 5'd9, 16'h7FFF, 5'd31, 8'h00, 0,
                                NO_BYTE, NO_BYTE, NO_BYTE));
    dir_table.push_back(dir_row(OP_SDEC, 2'd1, 5'd12, 16'hFFFF, 5'd3, 8'h00, 0,
                                NO_BYTE, NO_BYTE, NO_BYTE));
    dir_table.push_back(dir_row(OP_SDEC, 2'd2, 5'd2, 16'h0000, 5'd5, 8'h00, 0,
                                NO_BYTE, NO_BYTE, NO_BYTE));
    dir_table.push_back(dir_row(OP_HEX, 2'd1, 5'd7, 16'hABCD, 5'd31, 8'h00, 0,
                                NO_BYTE, NO_BYTE, NO_BYTE));
    dir_table.push_back(dir_row(OP_HEX, 2'd2, 5'd4, 16'hEF98, 5'd4, 8'h00, 0,
                                NO_BYTE, NO_BYTE, NO_BYTE));
    dir_table.push_back(dir_row(OP_HEX, 2'd1, 5'd14, 16'h09F0, 5'd3, 8'h00, 0,
                                NO_BYTE, NO_BYTE, NO_BYTE));
    dir_table.push_back(dir_row(OP_BIN, 2'd2, 5'd1, 16'hFFFF, 5'd31, 8'h00, 0,
                                NO_BYTE, NO_BYTE, NO_BYTE));
    dir_table.push_back(dir_row(OP_BIN, 2'd1, 5'd1, 16'hA5A5, 5'd16, 8'h00, 0,
                                NO_BYTE, NO_BYTE, NO_BYTE));
    dir_table.push_back(dir_row(OP_BIN, 2'd2, 5'd1, 16'h5A5A, 5'd17, 8'h00, 0,
                                NO_BYTE, NO_BYTE, NO_BYTE));
    dir_table.push_back(dir_row(OP_BIN, 2'd1, 5'd16, 16'h0001, 5'd1, 8'h00, 0,
                                NO_BYTE, NO_BYTE, NO_BYTE));
    dir_table.push_back(dir_row(OP_CHAR, 2'd1, 5'd8, 16'h0000, 5'd5, 8'h41, 0,
                                NO_BYTE, NO_BYTE, NO_BYTE));

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    for (k = 0; k < dir_table.size(); k++) begin
      r = dir_table[k];
      send_request(r.req);
      if (r.n_typed != 0) begin
        for (j = 0; j < r.n_typed; j++) expected_bytes.push_back(r.typed[j]);
      end else begin
        format_request(r.req);
      end
      if ($urandom_range(0, 3) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
    end

    burst_left = 0;
    for (k = 0; k < N_RANDOM; k++) begin
      if (k % PAUSE_EVERY == 0) begin
        // hold off until the block has emptied out
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_bytes.size() != 0) @(posedge clk);
      end else if (burst_left == 0) begin
        burst_left = $urandom_range(1, 10);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      if ($urandom_range(0, 9) == 0)
        req.op = 3'($urandom_range(OP_RSVD5, OP_RSVD7));
      else
        req.op = 3'($urandom_range(OP_CHAR, OP_BIN));
      req.row_sel = ($urandom_range(0, 4) == 0) ? 2'($urandom) : 2'($urandom_range(1, 2));
      req.col_pos = ($urandom_range(0, 6) == 0) ? 5'($urandom) : 5'($urandom_range(1, 16));
      case ($urandom_range(0, 7))
        0:       req.num_value = 16'h0000;
        1:       req.num_value = 16'h8000;
        2:       req.num_value = 16'h7FFF;
        3:       req.num_value = 16'hFFFF;
        default: req.num_value = 16'($urandom);
      endcase
      if ($urandom_range(0, 7) == 0)
        req.digit_count = 5'($urandom);
      else
        req.digit_count = 5'($urandom_range(0, (req.op == OP_BIN) ? 17 : 6));
      req.char_code = 8'($urandom);
      send_request(req);
      format_request(req);
      if (burst_left > 0) burst_left--;
    end
    in_valid <= 1'b0;

    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d requests (%0d from the table), %0d bus bytes compared",
             dir_table.size() + N_RANDOM, dir_table.size(), bytes_checked);
    $display("by op char/udec/sdec/hex/bin/unused: %0d/%0d/%0d/%0d/%0d/%0d, %0d failures",
             op_seen[OP_CHAR], op_seen[OP_UDEC], op_seen[OP_SDEC], op_seen[OP_HEX],
             op_seen[OP_BIN], op_seen[OP_RSVD5] + op_seen[OP_RSVD6] + op_seen[OP_RSVD7],
             fail_count);
    if (fail_count == 0 && expected_bytes.size() == 0)
      $display("** lcd_number_to_char_writer: PASSED **");
    else
      $display("** lcd_number_to_char_writer: FAILED **");
    $finish;
  end

endmodule

// ===== lcd_number_to_char_writer.f =====
design/lcdw_pkg.sv
design/lcdw_dabble.sv
design/lcd_number_to_char_writer.sv
tb/tb.sv
